[design/gsrc_pkg.sv]
// Package for the gear sensor range calibrator.
// Holds sizes, command and mode codes, sequencer states and shared structs.
// No dependencies.
package gsrc_pkg;

  localparam int GEARS       = 9;
  localparam int SENSORS     = 3;
  localparam int SAMPLE_BITS = 10;

  // Fixed port widths of the word fields
  localparam int KIND_W    = 3;
  localparam int GEAR_W    = 4;
  localparam int SAMPLE_W  = 10;
  localparam int MODE_W    = 3;
  localparam int OUTCOME_W = 2;

  localparam int SLOTS   = GEARS * SENSORS;
  localparam int SLOT_W  = $clog2(SLOTS);
  localparam int SENS_W  = (SENSORS > 1) ? $clog2(SENSORS) : 1;
  localparam int LAST_A  = SLOTS - SENSORS - 1;
  localparam int CHK_W   = SAMPLE_BITS + 5;

  localparam logic [KIND_W-1:0] KIND_START  = 3'd0;
  localparam logic [KIND_W-1:0] KIND_RECORD = 3'd1;
  localparam logic [KIND_W-1:0] KIND_STOP   = 3'd2;
  localparam logic [KIND_W-1:0] KIND_ABORT  = 3'd3;
  localparam logic [KIND_W-1:0] KIND_FINISH = 3'd4;

  localparam logic [OUTCOME_W-1:0] OUT_NONE = 2'd0;
  localparam logic [OUTCOME_W-1:0] OUT_PASS = 2'd1;
  localparam logic [OUTCOME_W-1:0] OUT_FAIL = 2'd2;

  typedef enum logic [MODE_W-1:0] {
    MODE_INITIAL   = 3'd0,
    MODE_WAITING   = 3'd1,
    MODE_RECORDING = 3'd2,
    MODE_CALIBRATE = 3'd3,
    MODE_ERROR     = 3'd4
  } mode_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_WID_RD,
    S_WID_WR,
    S_CHK_RDA,
    S_CHK_RDB,
    S_CHK_EVAL,
    S_COPY_RD,
    S_COPY_WR,
    S_DONE
  } seq_state_t;

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] lo;
    logic [SAMPLE_BITS-1:0] hi;
  } bound_t;

  localparam bound_t BOUND_RESET = '{lo: '1, hi: '0};

  typedef logic [SENSORS-1:0][SAMPLE_BITS-1:0] sample_arr_t;

  typedef struct packed {
    logic              clr;
    logic [SLOT_W-1:0] rd_addr;
    logic              wr_en;
    logic [SLOT_W-1:0] wr_addr;
    bound_t            wr_data;
    logic              live_we;
    logic [SLOT_W-1:0] live_addr;
  } store_ctl_t;

endpackage

[design/gsrc_range_unit.sv]
// Shared bound arithmetic: widen one bound pair by a sample, and check the
// separation of two adjacent gear ranges. Depends on gsrc_pkg.
module gsrc_range_unit (
  input  gsrc_pkg::bound_t                    a_i,
  input  gsrc_pkg::bound_t                    b_i,
  input  logic [gsrc_pkg::SAMPLE_BITS-1:0]    sample_i,
  output gsrc_pkg::bound_t                    widened_o,
  output logic                                fail_o
);

  logic signed [gsrc_pkg::CHK_W-1:0] ra;
  logic signed [gsrc_pkg::CHK_W-1:0] rb;
  logic signed [gsrc_pkg::CHK_W-1:0] gap;
  logic signed [gsrc_pkg::CHK_W-1:0] lhs;
  logic signed [gsrc_pkg::CHK_W-1:0] rhs;

  always_comb begin
    widened_o.lo = (sample_i < a_i.lo) ? sample_i : a_i.lo;
    widened_o.hi = (sample_i > a_i.hi) ? sample_i : a_i.hi;
  end

  // 5*gap >= 2*(ra+rb) is the fixed-point form of gap >= 0.8 * mean range
  always_comb begin
    ra  = $signed(gsrc_pkg::CHK_W'(a_i.hi)) - $signed(gsrc_pkg::CHK_W'(a_i.lo));
    rb  = $signed(gsrc_pkg::CHK_W'(b_i.hi)) - $signed(gsrc_pkg::CHK_W'(b_i.lo));
    gap = $signed(gsrc_pkg::CHK_W'(b_i.lo)) - $signed(gsrc_pkg::CHK_W'(a_i.hi));
    lhs = (gap <<< 2) + gap;
    rhs = (ra + rb) <<< 1;
    fail_o = (ra == '0) || (rb == '0) || (lhs < rhs);
  end

endmodule

[design/gsrc_bound_store.sv]
// Recorded bound memory with per-slot valid bits, plus the live mapping store.
// Depends on gsrc_pkg.
module gsrc_bound_store (
  input  logic                 clk,
  input  logic                 rst_n,
  input  gsrc_pkg::store_ctl_t ctl_i,
  output gsrc_pkg::bound_t     rd_data_o
);

  gsrc_pkg::bound_t         rec_mem  [gsrc_pkg::SLOTS];
  gsrc_pkg::bound_t         live_mem [gsrc_pkg::SLOTS];
  logic [gsrc_pkg::SLOTS-1:0] valid_r;
  gsrc_pkg::bound_t         rd_raw_r;
  logic                     rd_vld_r;

  always_ff @(posedge clk) begin
    if (ctl_i.wr_en) begin
      rec_mem[ctl_i.wr_addr] <= ctl_i.wr_data;
    end
    rd_raw_r <= rec_mem[ctl_i.rd_addr];
  end

  // Clear drops every slot back to its reset bounds at once
  always_ff @(posedge clk) begin
    if (!rst_n || ctl_i.clr) begin
      valid_r  <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (ctl_i.wr_en) begin
        valid_r[ctl_i.wr_addr] <= 1'b1;
      end
      rd_vld_r <= valid_r[ctl_i.rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl_i.live_we) begin
      live_mem[ctl_i.live_addr] <= rd_data_o;
    end
  end

  assign rd_data_o = rd_vld_r ? rd_raw_r : gsrc_pkg::BOUND_RESET;

endmodule

[design/gsrc_seq.sv]
// Command sequencer: holds the mode, steps the shared range unit over the
// bound store for record and check, and copies bounds to the live store. Depends on gsrc_pkg.
module gsrc_seq (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start_i,
  input  logic [gsrc_pkg::KIND_W-1:0]        kind_i,
  input  logic [gsrc_pkg::GEAR_W-1:0]        gear_i,
  input  gsrc_pkg::sample_arr_t              samples_i,
  input  logic                               out_free_i,
  input  gsrc_pkg::bound_t                   rd_data_i,
  input  gsrc_pkg::bound_t                   widened_i,
  input  logic                               fail_i,
  output logic                               idle_o,
  output logic                               done_o,
  output gsrc_pkg::mode_t                    mode_o,
  output logic [gsrc_pkg::OUTCOME_W-1:0]     outcome_o,
  output gsrc_pkg::store_ctl_t               ctl_o,
  output gsrc_pkg::bound_t                   unit_a_o,
  output logic [gsrc_pkg::SAMPLE_BITS-1:0]   unit_sample_o
);

  gsrc_pkg::seq_state_t                state_r, state_nxt;
  gsrc_pkg::mode_t                     mode_r, mode_nxt;
  logic [gsrc_pkg::OUTCOME_W-1:0]      outcome_r, outcome_nxt;
  logic [gsrc_pkg::KIND_W-1:0]         kind_r;
  logic [gsrc_pkg::GEAR_W-1:0]         gear_r;
  gsrc_pkg::sample_arr_t               samp_r;
  logic [gsrc_pkg::SLOT_W-1:0]         slot_r, slot_nxt;
  logic [gsrc_pkg::SENS_W-1:0]         sens_r, sens_nxt;
  gsrc_pkg::bound_t                    hold_r, hold_nxt;
  logic                                gear_ok;
  logic                                last_sens;
  logic                                last_a;
  logic                                last_slot;

  assign gear_ok   = int'(gear_r) < gsrc_pkg::GEARS;
  assign last_sens = sens_r == gsrc_pkg::SENS_W'(gsrc_pkg::SENSORS - 1);
  assign last_a    = slot_r == gsrc_pkg::SLOT_W'(gsrc_pkg::LAST_A);
  assign last_slot = slot_r == gsrc_pkg::SLOT_W'(gsrc_pkg::SLOTS - 1);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      gsrc_pkg::S_IDLE: begin
        if (start_i) state_nxt = gsrc_pkg::S_DECODE;
      end
      gsrc_pkg::S_DECODE: begin
        state_nxt = gsrc_pkg::S_DONE;
        if (kind_r == gsrc_pkg::KIND_RECORD && mode_r == gsrc_pkg::MODE_RECORDING &&
            gear_ok) begin
          state_nxt = gsrc_pkg::S_WID_RD;
        end else if (kind_r == gsrc_pkg::KIND_FINISH &&
                     mode_r == gsrc_pkg::MODE_CALIBRATE) begin
          state_nxt = gsrc_pkg::S_CHK_RDA;
        end
      end
      gsrc_pkg::S_WID_RD:  state_nxt = gsrc_pkg::S_WID_WR;
      gsrc_pkg::S_WID_WR: begin
        state_nxt = last_sens ? gsrc_pkg::S_DONE : gsrc_pkg::S_WID_RD;
      end
      gsrc_pkg::S_CHK_RDA: state_nxt = gsrc_pkg::S_CHK_RDB;
      gsrc_pkg::S_CHK_RDB: state_nxt = gsrc_pkg::S_CHK_EVAL;
      gsrc_pkg::S_CHK_EVAL: begin
        if (fail_i)      state_nxt = gsrc_pkg::S_DONE;
        else if (last_a) state_nxt = gsrc_pkg::S_COPY_RD;
        else             state_nxt = gsrc_pkg::S_CHK_RDA;
      end
      gsrc_pkg::S_COPY_RD: state_nxt = gsrc_pkg::S_COPY_WR;
      gsrc_pkg::S_COPY_WR: begin
        state_nxt = last_slot ? gsrc_pkg::S_DONE : gsrc_pkg::S_COPY_RD;
      end
      gsrc_pkg::S_DONE: begin
        if (out_free_i) state_nxt = gsrc_pkg::S_IDLE;
      end
      default: state_nxt = gsrc_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    mode_nxt      = mode_r;
    outcome_nxt   = outcome_r;
    slot_nxt      = slot_r;
    sens_nxt      = sens_r;
    hold_nxt      = hold_r;
    ctl_o         = '0;
    ctl_o.rd_addr = slot_r;
    ctl_o.wr_addr = slot_r;
    ctl_o.wr_data = widened_i;
    ctl_o.live_addr = slot_r;
    unit_a_o      = rd_data_i;
    unit_sample_o = samp_r[sens_r];
    case (state_r)
      gsrc_pkg::S_DECODE: begin
        outcome_nxt = gsrc_pkg::OUT_NONE;
        case (kind_r)
          gsrc_pkg::KIND_START: begin
            ctl_o.clr = 1'b1;
            mode_nxt  = gsrc_pkg::MODE_WAITING;
          end
          gsrc_pkg::KIND_RECORD: begin
            if (mode_r == gsrc_pkg::MODE_WAITING) begin
              mode_nxt = gsrc_pkg::MODE_RECORDING;
            end
            slot_nxt = gsrc_pkg::SLOT_W'(int'(gear_r) * gsrc_pkg::SENSORS);
            sens_nxt = '0;
          end
          gsrc_pkg::KIND_STOP: begin
            if (mode_r == gsrc_pkg::MODE_RECORDING) mode_nxt = gsrc_pkg::MODE_WAITING;
          end
          gsrc_pkg::KIND_ABORT: begin
            if (mode_r != gsrc_pkg::MODE_INITIAL) begin
              ctl_o.clr = 1'b1;
              mode_nxt  = gsrc_pkg::MODE_INITIAL;
            end
          end
          gsrc_pkg::KIND_FINISH: begin
            if (mode_r == gsrc_pkg::MODE_WAITING) mode_nxt = gsrc_pkg::MODE_CALIBRATE;
            slot_nxt = '0;
          end
          default: ;
        endcase
      end
      gsrc_pkg::S_WID_WR: begin
        ctl_o.wr_en = 1'b1;
        slot_nxt    = slot_r + 1'b1;
        sens_nxt    = sens_r + 1'b1;
      end
      gsrc_pkg::S_CHK_RDB: begin
        ctl_o.rd_addr = gsrc_pkg::SLOT_W'(int'(slot_r) + gsrc_pkg::SENSORS);
        hold_nxt      = rd_data_i;
      end
      gsrc_pkg::S_CHK_EVAL: begin
        unit_a_o = hold_r;
        if (fail_i) begin
          mode_nxt    = gsrc_pkg::MODE_ERROR;
          outcome_nxt = gsrc_pkg::OUT_FAIL;
        end else if (last_a) begin
          slot_nxt = '0;
        end else begin
          slot_nxt = slot_r + 1'b1;
        end
      end
      gsrc_pkg::S_COPY_WR: begin
        ctl_o.live_we = 1'b1;
        if (last_slot) begin
          ctl_o.clr   = 1'b1;
          mode_nxt    = gsrc_pkg::MODE_INITIAL;
          outcome_nxt = gsrc_pkg::OUT_PASS;
        end else begin
          slot_nxt = slot_r + 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= gsrc_pkg::S_IDLE;
      mode_r  <= gsrc_pkg::MODE_INITIAL;
    end else begin
      state_r <= state_nxt;
      mode_r  <= mode_nxt;
    end
  end

  always_ff @(posedge clk) begin
    outcome_r <= outcome_nxt;
    slot_r    <= slot_nxt;
    sens_r    <= sens_nxt;
    hold_r    <= hold_nxt;
    if (start_i && state_r == gsrc_pkg::S_IDLE) begin
      kind_r <= kind_i;
      gear_r <= gear_i;
      samp_r <= samples_i;
    end
  end

  assign idle_o    = state_r == gsrc_pkg::S_IDLE;
  assign done_o    = (state_r == gsrc_pkg::S_DONE) && out_free_i;
  assign mode_o    = mode_r;
  assign outcome_o = outcome_r;

endmodule

[design/gear_sensor_range_calibrator.sv]
// Gear sensor range calibrator, top level.
// Depends on gsrc_pkg, gsrc_range_unit, gsrc_bound_store and gsrc_seq.
//
// Usage: each input word carries a command (in_kind), a gear slot
// (in_gear_index) and one ADC sample per sensor. Every accepted word yields
// exactly one result word: the mode after the command and the outcome of a
// calibration check (nothing, stored, failed). There is no configuration port.
//
// Flow: the block takes one word at a time and drops
// in_ready until that word's result sits in the output register. A plain
// command (start, stop, abort, no command, mode-only record or finish) goes
// straight from decode to done. A sample record runs the shared range unit
// once per sensor, a read and then a widened write-back, over the one read
// port of the bound memory. A finishing check reads both gears of each of the
// (GEARS-1)*SENSORS = 24 adjacent pairs, reading one, then the other, then
// evaluating, and on success copies the GEARS*SENSORS = 27 bound pairs into
// the live store, a read and a write each.
//
// Reset (rst_n low, synchronous) returns the mode to initial, marks every
// recorded bound as unwritten (reads as min 1023, max 0) and empties the
// output register, with no clearing pass.
// Stall: the output register holds a result until out_ready; a new word may
// be accepted meanwhile, and its result waits in the sequencer until the
// register frees.
module gear_sensor_range_calibrator (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [gsrc_pkg::KIND_W-1:0]       in_kind,
  input  logic [gsrc_pkg::GEAR_W-1:0]       in_gear_index,
  input  logic [gsrc_pkg::SAMPLE_W-1:0]     in_sample_0,
  input  logic [gsrc_pkg::SAMPLE_W-1:0]     in_sample_1,
  input  logic [gsrc_pkg::SAMPLE_W-1:0]     in_sample_2,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [gsrc_pkg::MODE_W-1:0]       out_mode,
  output logic [gsrc_pkg::OUTCOME_W-1:0]    out_outcome
);

  gsrc_pkg::sample_arr_t               samples;
  gsrc_pkg::store_ctl_t                store_ctl;
  gsrc_pkg::bound_t                    rd_data;
  gsrc_pkg::bound_t                    unit_a;
  gsrc_pkg::bound_t                    widened;
  logic [gsrc_pkg::SAMPLE_BITS-1:0]    unit_sample;
  logic                                unit_fail;
  logic                                seq_idle;
  logic                                seq_done;
  gsrc_pkg::mode_t                     seq_mode;
  logic [gsrc_pkg::OUTCOME_W-1:0]      seq_outcome;
  logic                                out_free;
  logic                                out_valid_r, out_valid_nxt;
  logic [gsrc_pkg::MODE_W-1:0]         out_mode_r;
  logic [gsrc_pkg::OUTCOME_W-1:0]      out_outcome_r;

  // Only the low SAMPLE_BITS of each sample take part
  assign samples[0] = gsrc_pkg::SAMPLE_BITS'(in_sample_0);
  assign samples[1] = gsrc_pkg::SAMPLE_BITS'(in_sample_1);
  assign samples[2] = gsrc_pkg::SAMPLE_BITS'(in_sample_2);

  assign in_ready = seq_idle;
  assign out_free = !out_valid_r || out_ready;

  gsrc_seq u_seq (
    .clk           (clk),
    .rst_n         (rst_n),
    .start_i       (in_valid),
    .kind_i        (in_kind),
    .gear_i        (in_gear_index),
    .samples_i     (samples),
    .out_free_i    (out_free),
    .rd_data_i     (rd_data),
    .widened_i     (widened),
    .fail_i        (unit_fail),
    .idle_o        (seq_idle),
    .done_o        (seq_done),
    .mode_o        (seq_mode),
    .outcome_o     (seq_outcome),
    .ctl_o         (store_ctl),
    .unit_a_o      (unit_a),
    .unit_sample_o (unit_sample)
  );

  gsrc_bound_store u_store (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl_i     (store_ctl),
    .rd_data_o (rd_data)
  );

  // Operand b is always the word just read: gear g+1 during a check
  gsrc_range_unit u_unit (
    .a_i       (unit_a),
    .b_i       (rd_data),
    .sample_i  (unit_sample),
    .widened_o (widened),
    .fail_o    (unit_fail)
  );

  // Output register: load on completion, hold while the receiver stalls
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (seq_done)       out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (seq_done) begin
      out_mode_r    <= seq_mode;
      out_outcome_r <= seq_outcome;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_mode    = out_mode_r;
  assign out_outcome = out_outcome_r;

endmodule

[tb/tb_gear_sensor_range_calibrator.sv]
// Self-checking testbench for gear_sensor_range_calibrator.
// Drives command words over valid/ready and checks each result word against an
// in-bench predictor of the calibration sequencer. Depends on gsrc_pkg and the DUT.
`timescale 1ns / 100ps

module tb_gear_sensor_range_calibrator;

  // Kind codes the package leaves unnamed: one idle command, two spare codes
  localparam logic [gsrc_pkg::KIND_W-1:0] KIND_IDLE  = 3'd5;
  localparam logic [gsrc_pkg::KIND_W-1:0] KIND_RSVD6 = 3'd6;
  localparam logic [gsrc_pkg::KIND_W-1:0] KIND_RSVD7 = 3'd7;

  localparam int SAMPLE_MAX   = (1 << gsrc_pkg::SAMPLE_BITS) - 1;
  localparam int GEAR_CODES   = (1 << gsrc_pkg::GEAR_W) - 1;
  localparam int BAND         = (SAMPLE_MAX + 1) / gsrc_pkg::GEARS;  // ADC span per gear slot
  localparam int RANDOM_WORDS = 1500;
  localparam int HOLD_OFF     = 400;   // long receiver stall, in cycles
  localparam int TAIL_CYCLES  = 160;   // idle wait after the final drain, in cycles
  // Cycle cap for the whole run; the hard stop below ends the run there.
  localparam int CYCLE_LIMIT  = 1_000_000;

  typedef struct packed {
    gsrc_pkg::mode_t                 mode;
    logic [gsrc_pkg::OUTCOME_W-1:0]  outcome;
  } calib_result_t;

  typedef struct packed {
    logic [gsrc_pkg::KIND_W-1:0]    kind;
    logic [gsrc_pkg::GEAR_W-1:0]    gear;
    logic [gsrc_pkg::SAMPLE_W-1:0]  s0;
    logic [gsrc_pkg::SAMPLE_W-1:0]  s1;
    logic [gsrc_pkg::SAMPLE_W-1:0]  s2;
    logic                           typed;    // expected result written in the row
    gsrc_pkg::mode_t                mode;
    logic [gsrc_pkg::OUTCOME_W-1:0] outcome;
  } probe_row_t;

  // Directed words. Rows with typed set carry an expectation that is plain
  // from the command sequence; the rest go through the predictor.
  localparam int NPROBES = 25;
  localparam probe_row_t PROBES [NPROBES] = '{
    // after reset: idle, abort, record and finish all leave initial alone
    '{KIND_IDLE,             4'd0,  10'h000, 10'h000, 10'h000,
      1'b1, gsrc_pkg::MODE_INITIAL,   gsrc_pkg::OUT_NONE},
    '{gsrc_pkg::KIND_ABORT,  4'd0,  10'h000, 10'h000, 10'h000,
      1'b1, gsrc_pkg::MODE_INITIAL,   gsrc_pkg::OUT_NONE},
    '{gsrc_pkg::KIND_RECORD, 4'd3,  10'h3ff, 10'h3ff, 10'h3ff,
      1'b1, gsrc_pkg::MODE_INITIAL,   gsrc_pkg::OUT_NONE},
    '{gsrc_pkg::KIND_FINISH, 4'd0,  10'h000, 10'h000, 10'h000,
      1'b1, gsrc_pkg::MODE_INITIAL,   gsrc_pkg::OUT_NONE},
    // nothing recorded: every range is the negative unwritten span
    '{gsrc_pkg::KIND_START,  4'd15, 10'h3ff, 10'h3ff, 10'h3ff,
      1'b1, gsrc_pkg::MODE_WAITING,   gsrc_pkg::OUT_NONE},
    '{gsrc_pkg::KIND_FINISH, 4'd0,  10'h000, 10'h000, 10'h000,
      1'b1, gsrc_pkg::MODE_CALIBRATE, gsrc_pkg::OUT_NONE},
    '{gsrc_pkg::KIND_FINISH, 4'd0,  10'h000, 10'h000, 10'h000,
      1'b0, gsrc_pkg::MODE_INITIAL,   gsrc_pkg::OUT_NONE},
    // entering record mode takes no samples
    '{gsrc_pkg::KIND_START,  4'd0,  10'h000, 10'h000, 10'h000,
      1'b1, gsrc_pkg::MODE_WAITING,   gsrc_pkg::OUT_NONE},
    '{gsrc_pkg::KIND_RECORD, 4'd5,  10'h2aa, 10'h155, 10'h3ff,
      1'b1, gsrc_pkg::MODE_RECORDING, gsrc_pkg::OUT_NONE},
    // full-scale range on gear 0, then an out-of-range gear and a spare code
    '{gsrc_pkg::KIND_RECORD, 4'd0,  10'h000, 10'h000, 10'h000,
      1'b0, gsrc_pkg::MODE_INITIAL,   gsrc_pkg::OUT_NONE},
    '{gsrc_pkg::KIND_RECORD, 4'd0,  10'h3ff, 10'h3ff, 10'h3ff,
      1'b0, gsrc_pkg::MODE_INITIAL,   gsrc_pkg::OUT_NONE},
    '{gsrc_pkg::KIND_RECORD, 4'd15, 10'h155, 10'h2aa, 10'h000,
      1'b0, gsrc_pkg::MODE_INITIAL,   gsrc_pkg::OUT_NONE},
    '{KIND_RSVD7,            4'd8,  10'h3ff, 10'h3ff, 10'h3ff,
      1'b1, gsrc_pkg::MODE_RECORDING, gsrc_pkg::OUT_NONE},
    '{gsrc_pkg::KIND_STOP,   4'd0,  10'h000, 10'h000, 10'h000,
      1'b1, gsrc_pkg::MODE_WAITING,   gsrc_pkg::OUT_NONE},
    '{gsrc_pkg::KIND_FINISH, 4'd0,  10'h000, 10'h000, 10'h000,
      1'b1, gsrc_pkg::MODE_CALIBRATE, gsrc_pkg::OUT_NONE},
    '{gsrc_pkg::KIND_RECORD, 4'd1,  10'h100, 10'h100, 10'h100,
      1'b1, gsrc_pkg::MODE_CALIBRATE, gsrc_pkg::OUT_NONE},
    // gear 0 spans the scale next to unwritten gear 1: gap test sits at equality
    '{gsrc_pkg::KIND_FINISH, 4'd0,  10'h000, 10'h000, 10'h000,
      1'b0, gsrc_pkg::MODE_INITIAL,   gsrc_pkg::OUT_NONE},
    // a single sample gives a zero-width range: the check must fail
    '{gsrc_pkg::KIND_START,  4'd0,  10'h000, 10'h000, 10'h000,
      1'b1, gsrc_pkg::MODE_WAITING,   gsrc_pkg::OUT_NONE},
    '{gsrc_pkg::KIND_RECORD, 4'd0,  10'h000, 10'h000, 10'h000,
      1'b1, gsrc_pkg::MODE_RECORDING, gsrc_pkg::OUT_NONE},
    '{gsrc_pkg::KIND_RECORD, 4'd8,  10'd200, 10'd300, 10'd700,
      1'b0, gsrc_pkg::MODE_INITIAL,   gsrc_pkg::OUT_NONE},
    '{gsrc_pkg::KIND_STOP,   4'd0,  10'h000, 10'h000, 10'h000,
      1'b1, gsrc_pkg::MODE_WAITING,   gsrc_pkg::OUT_NONE},
    '{gsrc_pkg::KIND_FINISH, 4'd0,  10'h000, 10'h000, 10'h000,
      1'b1, gsrc_pkg::MODE_CALIBRATE, gsrc_pkg::OUT_NONE},
    '{gsrc_pkg::KIND_FINISH, 4'd0,  10'h000, 10'h000, 10'h000,
      1'b1, gsrc_pkg::MODE_ERROR,     gsrc_pkg::OUT_FAIL},
    // error mode: finish is ignored, abort leaves
    '{gsrc_pkg::KIND_FINISH, 4'd0,  10'h000, 10'h000, 10'h000,
      1'b1, gsrc_pkg::MODE_ERROR,     gsrc_pkg::OUT_NONE},
    '{gsrc_pkg::KIND_ABORT,  4'd0,  10'h000, 10'h000, 10'h000,
      1'b1, gsrc_pkg::MODE_INITIAL,   gsrc_pkg::OUT_NONE}
  };

  logic                            clk;
  logic                            rst_n         = 1'b0;
  logic                            in_valid      = 1'b0;
  logic                            in_ready;
  logic [gsrc_pkg::KIND_W-1:0]     in_kind       = '0;
  logic [gsrc_pkg::GEAR_W-1:0]     in_gear_index = '0;
  logic [gsrc_pkg::SAMPLE_W-1:0]   in_sample_0   = '0;
  logic [gsrc_pkg::SAMPLE_W-1:0]   in_sample_1   = '0;
  logic [gsrc_pkg::SAMPLE_W-1:0]   in_sample_2   = '0;
  logic                            out_valid;
  logic                            out_ready     = 1'b0;
  logic [gsrc_pkg::MODE_W-1:0]     out_mode;
  logic [gsrc_pkg::OUTCOME_W-1:0]  out_outcome;

  // Predictor state: mode and recorded bounds; the live map is written on a
  // stored calibration and never read back.
  gsrc_pkg::mode_t                  mode_q;
  logic [gsrc_pkg::SAMPLE_BITS-1:0] rec_lo  [gsrc_pkg::SLOTS];
  logic [gsrc_pkg::SAMPLE_BITS-1:0] rec_hi  [gsrc_pkg::SLOTS];
  logic [gsrc_pkg::SAMPLE_BITS-1:0] live_lo [gsrc_pkg::SLOTS];
  logic [gsrc_pkg::SAMPLE_BITS-1:0] live_hi [gsrc_pkg::SLOTS];

  calib_result_t due_results [$];   // results owed by the block, oldest first
  calib_result_t head_result;
  int            mismatches   = 0;
  int            words_taken  = 0;
  int            results_seen = 0;
  int            burst_left   = 0;
  int            cycle_count  = 0;

  gear_sensor_range_calibrator dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_kind       (in_kind),
    .in_gear_index (in_gear_index),
    .in_sample_0   (in_sample_0),
    .in_sample_1   (in_sample_1),
    .in_sample_2   (in_sample_2),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_mode      (out_mode),
    .out_outcome   (out_outcome)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Hard stop: a hung handshake ends the run here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  task automatic flag_mismatch(input string what);
    $display("[%0t] mismatch: %s", $time, what);
    mismatches++;
  endtask

  function automatic void wipe_recorder();
    for (int k = 0; k < gsrc_pkg::SLOTS; k++) begin
      rec_lo[k] = '1;
      rec_hi[k] = '0;
    end
  endfunction

  function automatic logic [gsrc_pkg::SAMPLE_W-1:0] any_sample();
    return gsrc_pkg::SAMPLE_W'($urandom_range(0, SAMPLE_MAX));
  endfunction

  function automatic logic [gsrc_pkg::GEAR_W-1:0] any_gear();
    return gsrc_pkg::GEAR_W'($urandom_range(0, GEAR_CODES));
  endfunction

  // Advance the sequencer by one command word and give the result it owes.
  task automatic advance_calibrator(input logic [gsrc_pkg::KIND_W-1:0] kind,
                                    input logic [gsrc_pkg::GEAR_W-1:0] gear,
                                    input logic [gsrc_pkg::SAMPLE_W-1:0] s0, s1, s2,
                                    output calib_result_t res);
    logic [gsrc_pkg::SAMPLE_BITS-1:0] smp [gsrc_pkg::SENSORS];
    logic [gsrc_pkg::OUTCOME_W-1:0]   oc;
    logic                             apart;
    int                               a, b, k, ra, rb, gap;
    smp[0] = s0;
    smp[1] = s1;
    smp[2] = s2;
    oc = gsrc_pkg::OUT_NONE;
    case (kind)
      gsrc_pkg::KIND_START: begin
        wipe_recorder();
        mode_q = gsrc_pkg::MODE_WAITING;
      end
      gsrc_pkg::KIND_RECORD: begin
        if (mode_q == gsrc_pkg::MODE_WAITING) begin
          mode_q = gsrc_pkg::MODE_RECORDING;
        end else if (mode_q == gsrc_pkg::MODE_RECORDING && int'(gear) < gsrc_pkg::GEARS) begin
          // widen this gear's bounds in place, per sensor
          for (int s = 0; s < gsrc_pkg::SENSORS; s++) begin
            k = int'(gear) * gsrc_pkg::SENSORS + s;
            if (smp[s] < rec_lo[k]) rec_lo[k] = smp[s];
            if (smp[s] > rec_hi[k]) rec_hi[k] = smp[s];
          end
        end
      end
      gsrc_pkg::KIND_STOP: begin
        if (mode_q == gsrc_pkg::MODE_RECORDING) mode_q = gsrc_pkg::MODE_WAITING;
      end
      gsrc_pkg::KIND_ABORT: begin
        if (mode_q != gsrc_pkg::MODE_INITIAL) begin
          wipe_recorder();
          mode_q = gsrc_pkg::MODE_INITIAL;
        end
      end
      gsrc_pkg::KIND_FINISH: begin
        if (mode_q == gsrc_pkg::MODE_WAITING) begin
          mode_q = gsrc_pkg::MODE_CALIBRATE;
        end else if (mode_q == gsrc_pkg::MODE_CALIBRATE) begin
          // every adjacent pair, every sensor: non-zero ranges and
          // 5*gap >= 2*(ra+rb); unwritten gears take part with negative ranges
          apart = 1'b1;
          for (int g = 0; g < gsrc_pkg::GEARS - 1; g++) begin
            for (int s = 0; s < gsrc_pkg::SENSORS; s++) begin
              a   = g * gsrc_pkg::SENSORS + s;
              b   = a + gsrc_pkg::SENSORS;
              ra  = int'(rec_hi[a]) - int'(rec_lo[a]);
              rb  = int'(rec_hi[b]) - int'(rec_lo[b]);
              gap = int'(rec_lo[b]) - int'(rec_hi[a]);
              if (ra == 0 || rb == 0 || 5 * gap < 2 * (ra + rb)) apart = 1'b0;
            end
          end
          if (apart) begin
            for (int i = 0; i < gsrc_pkg::SLOTS; i++) begin
              live_lo[i] = rec_lo[i];
              live_hi[i] = rec_hi[i];
            end
            wipe_recorder();
            mode_q = gsrc_pkg::MODE_INITIAL;
            oc = gsrc_pkg::OUT_PASS;
          end else begin
            mode_q = gsrc_pkg::MODE_ERROR;
            oc = gsrc_pkg::OUT_FAIL;
          end
        end
      end
      default: ;   // idle and spare codes change nothing
    endcase
    res.mode    = mode_q;
    res.outcome = oc;
  endtask

  // Offer one word and hold it until taken; then log what the block owes and
  // advance the burst, dropping valid for a random gap when the burst ends.
  task automatic offer_word(input logic [gsrc_pkg::KIND_W-1:0] kind,
                            input logic [gsrc_pkg::GEAR_W-1:0] gear,
                            input logic [gsrc_pkg::SAMPLE_W-1:0] s0, s1, s2,
                            input logic typed = 1'b0,
                            input gsrc_pkg::mode_t t_mode = gsrc_pkg::MODE_INITIAL,
                            input logic [gsrc_pkg::OUTCOME_W-1:0] t_outcome =
                              gsrc_pkg::OUT_NONE);
    calib_result_t r;
    in_valid      <= 1'b1;
    in_kind       <= kind;
    in_gear_index <= gear;
    in_sample_0   <= s0;
    in_sample_1   <= s1;
    in_sample_2   <= s2;
    do @(posedge clk); while (!in_ready);
    words_taken++;
    advance_calibrator(kind, gear, s0, s1, s2, r);
    if (typed) begin
      r.mode    = t_mode;
      r.outcome = t_outcome;
    end
    due_results.push_back(r);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      // mostly short bursts, now and then a long one with no gaps at all
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(100, 300)
                                               : $urandom_range(1, 25);
    end
  endtask

  // Drop valid and wait for every owed result to come back.
  task automatic hold_until_drained();
    in_valid <= 1'b0;
    while (due_results.size() != 0) @(posedge clk);
  endtask

  // One calibration sequence with random content: start (now and then left out),
  // enter record mode, widen the bounds of most gears from per-gear bands, stop,
  // finish twice. The band width, a reversed sensor, an unwritten gear or a lone
  // sample now and then decide pass or fail; rare noise words break the sequence up.
  task automatic run_calibration_pass();
    int lo [gsrc_pkg::GEARS][gsrc_pkg::SENSORS];
    int hi [gsrc_pkg::GEARS][gsrc_pkg::SENSORS];
    bit desc [gsrc_pkg::SENSORS];
    int v [gsrc_pkg::SENSORS];
    int wmax, offset, slot, g, n;
    wmax   = 4 + 30 * $urandom_range(0, 4);
    offset = $urandom_range(0, gsrc_pkg::GEARS - 1);
    for (int s = 0; s < gsrc_pkg::SENSORS; s++) desc[s] = ($urandom_range(0, 7) == 0);
    for (int gi = 0; gi < gsrc_pkg::GEARS; gi++) begin
      for (int s = 0; s < gsrc_pkg::SENSORS; s++) begin
        slot = desc[s] ? gsrc_pkg::GEARS - 1 - gi : gi;
        lo[gi][s] = slot * BAND + $urandom_range(0, 12);
        hi[gi][s] = lo[gi][s] + $urandom_range(0, wmax);
        if (hi[gi][s] > SAMPLE_MAX) hi[gi][s] = SAMPLE_MAX;
      end
    end

    if ($urandom_range(0, 11) != 0)
      offer_word(gsrc_pkg::KIND_START, any_gear(), any_sample(), any_sample(),
                 any_sample());
    offer_word(gsrc_pkg::KIND_RECORD, any_gear(), any_sample(), any_sample(),
               any_sample());

    for (int step = 0; step < gsrc_pkg::GEARS; step++) begin
      g = (step + offset) % gsrc_pkg::GEARS;
      if ($urandom_range(0, 9) == 0) continue;   // leave this gear unwritten
      n = ($urandom_range(0, 29) == 0) ? 1 : $urandom_range(2, 4);
      for (int j = 0; j < n; j++) begin
        case ($urandom_range(0, 79))
          0: offer_word(KIND_IDLE, any_gear(), any_sample(), any_sample(), any_sample());
          1: offer_word(KIND_RSVD6, any_gear(), any_sample(), any_sample(), any_sample());
          2: offer_word(KIND_RSVD7, any_gear(), any_sample(), any_sample(), any_sample());
          3: offer_word(gsrc_pkg::KIND_RECORD,
                        gsrc_pkg::GEAR_W'($urandom_range(gsrc_pkg::GEARS, GEAR_CODES)),
                        any_sample(), any_sample(), any_sample());
          4: begin
            // leave record mode and come back: the re-entry takes no samples
            offer_word(gsrc_pkg::KIND_STOP, any_gear(), any_sample(), any_sample(),
                       any_sample());
            offer_word(gsrc_pkg::KIND_RECORD, any_gear(), any_sample(), any_sample(),
                       any_sample());
          end
          5: offer_word(gsrc_pkg::KIND_ABORT, any_gear(), any_sample(), any_sample(),
                        any_sample());
          default: ;
        endcase
        // first word hits the low end, second the high end, the rest between
        for (int s = 0; s < gsrc_pkg::SENSORS; s++) begin
          v[s] = (j == 0) ? lo[g][s] :
                 (j == 1) ? hi[g][s] : $urandom_range(hi[g][s], lo[g][s]);
        end
        offer_word(gsrc_pkg::KIND_RECORD, gsrc_pkg::GEAR_W'(g),
                   gsrc_pkg::SAMPLE_W'(v[0]), gsrc_pkg::SAMPLE_W'(v[1]),
                   gsrc_pkg::SAMPLE_W'(v[2]));
      end
    end

    offer_word(gsrc_pkg::KIND_STOP, any_gear(), any_sample(), any_sample(), any_sample());
    offer_word(gsrc_pkg::KIND_FINISH, any_gear(), any_sample(), any_sample(),
               any_sample());
    if ($urandom_range(0, 7) == 0)
      offer_word(gsrc_pkg::KIND_RECORD, any_gear(), any_sample(), any_sample(),
                 any_sample());
    offer_word(gsrc_pkg::KIND_FINISH, any_gear(), any_sample(), any_sample(),
               any_sample());
  endtask

  // Result checker: compare each taken result with the oldest owed one.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      results_seen++;
      if (due_results.size() == 0) begin
        flag_mismatch($sformatf("unowed result mode %0d outcome %0d",
                                out_mode, out_outcome));
      end else begin
        head_result = due_results.pop_front();
        if (out_mode !== head_result.mode)
          flag_mismatch($sformatf("mode %0d, predicted %0d", out_mode, head_result.mode));
        if (out_outcome !== head_result.outcome)
          flag_mismatch($sformatf("outcome %0d, predicted %0d",
                                  out_outcome, head_result.outcome));
      end
    end
  end

  // Receiver: phases of steady, random and patterned stalls, plus one long
  // hold-off so that the block fills up and stalls its input.
  initial begin : receiver
    int  style, phase_len;
    bit  held;
    held = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      style     = $urandom_range(0, 3);
      phase_len = $urandom_range(10, 150);
      for (int tick = 0; tick < phase_len; tick++) begin
        @(posedge clk);
        if (!held && results_seen >= 300) begin
          out_ready <= 1'b0;
          repeat (HOLD_OFF) @(posedge clk);
          held = 1'b1;
        end else begin
          case (style)
            0:       out_ready <= 1'b1;
            1:       out_ready <= ($urandom_range(0, 1) == 1);
            2:       out_ready <= (tick % 4 != 3);
            default: out_ready <= ($urandom_range(0, 5) == 0);
          endcase
        end
      end
    end
  end

  // Stimulus: reset, directed rows, then random calibration passes.
  initial begin
    int pass_no;
    mode_q = gsrc_pkg::MODE_INITIAL;
    wipe_recorder();
    for (int i = 0; i < gsrc_pkg::SLOTS; i++) begin
      live_lo[i] = '0;
      live_hi[i] = '0;
    end

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < NPROBES; i++) begin
      offer_word(PROBES[i].kind, PROBES[i].gear, PROBES[i].s0, PROBES[i].s1,
                 PROBES[i].s2, PROBES[i].typed, PROBES[i].mode, PROBES[i].outcome);
    end

    pass_no = 0;
    while (words_taken < NPROBES + RANDOM_WORDS) begin
      // once, mid-run: pause until the block has nothing left to return
      if (pass_no == 12) hold_until_drained();
      run_calibration_pass();
      repeat ($urandom_range(0, 4))
        offer_word(gsrc_pkg::KIND_W'($urandom_range(0, 7)), any_gear(), any_sample(),
                   any_sample(), any_sample());
      pass_no++;
    end

    hold_until_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule

[files.f]
design/gsrc_pkg.sv
design/gsrc_range_unit.sv
design/gsrc_bound_store.sv
design/gsrc_seq.sv
design/gear_sensor_range_calibrator.sv
tb/tb_gear_sensor_range_calibrator.sv
